// ===== design/mf3_pkg.sv =====
// Shared types and the nine-input median network for the 3x3 median filter.
// No dependencies.
package mf3_pkg;

    localparam int PIX_W   = 8;
    localparam int WIN_N   = 9;
    localparam int FW_W    = 11;
    localparam int FH_W    = 13;
    localparam int ROW_W   = 12;
    localparam int MAX_HEIGHT = 4096;
    localparam int APB_AW  = 3;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] pixel_t;
    typedef pixel_t win_t [WIN_N];

    // Fixed 19-exchange median network.
    function automatic pixel_t median9(input win_t w);
        pixel_t p [WIN_N];
        pixel_t t;
        int     a [19];
        int     b [19];
        a = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
        b = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};
        p = w;
        for (int i = 0; i < 19; i++) begin
            if (p[a[i]] > p[b[i]]) begin
                t       = p[a[i]];
                p[a[i]] = p[b[i]];
                p[b[i]] = t;
            end
        end
        return p[4];
    endfunction

endpackage

// ===== design/median_filter_3x3.sv =====
// 3x3 median filter over a raster stream of 8-bit grey pixels.
// Depends on mf3_pkg.
//
// Pixels enter one per transaction in raster order; one pixel can be taken every clock.
// The output carries the median of each interior 3x3 neighbourhood, so a frame of
// W x H pixels gives (W-2) x (H-2) results in raster order, with tlast on the last.
// A median goes from the edge that accepts the pixel that completes its window through the
// line store read, the window register and the median network into the output
// register. The input stalls only while all three stages hold and a result waits on
// m_tready. Two line stores of MAX_WIDTH entries hold the previous rows. Any register
// write restarts the frame.
module median_filter_3x3 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  mf3_pkg::pixel_t               s_tdata,   // [7:0] pixel_in
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output mf3_pkg::pixel_t               m_tdata,   // [7:0] median_out
    output logic                          m_tlast,   // frame_last
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mf3_pkg::APB_AW-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import mf3_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    logic [FW_W-1:0]  frame_width_reg;
    logic [FH_W-1:0]  frame_height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_last;
    logic [ROW_W-1:0] row_last;
    logic             cfg_wr;
    logic             s_acc;

    // stage A: accepted pixel, line store read in flight
    logic             a_valid_reg;
    pixel_t           a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    logic             a_emit_reg;
    logic             a_last_reg;
    pixel_t           up_rd_reg;
    pixel_t           mid_rd_reg;
    logic             a_adv;

    // stage B: window
    logic             b_valid_reg;
    logic             b_emit_reg;
    logic             b_last_reg;
    win_t             win_reg;
    logic             b_adv;
    logic             b_free;

    // stage C: output register
    logic             c_valid_reg;
    pixel_t           c_data_reg;
    logic             c_last_reg;
    logic             c_ready;

    pixel_t line_upper [MAX_WIDTH];
    pixel_t line_middle [MAX_WIDTH];

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_FRAME_HEIGHT) ? 32'(frame_height_reg)
                                                   : 32'(frame_width_reg);

    always_comb begin
        if (frame_width_reg < FW_W'(3))
            col_last = COL_W'(2);
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(frame_width_reg - FW_W'(1));

        if (frame_height_reg < FH_W'(3))
            row_last = ROW_W'(2);
        else if (32'(frame_height_reg) > 32'(MAX_HEIGHT))
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(frame_height_reg - FH_W'(1));
    end

    assign c_ready  = !c_valid_reg || m_tready;
    assign b_adv    = b_valid_reg && (!b_emit_reg || c_ready);
    assign b_free   = !b_valid_reg || b_adv;
    assign a_adv    = a_valid_reg && b_free;
    assign s_tready = !a_valid_reg || a_adv;
    assign s_acc    = s_tvalid && s_tready;

    assign m_tvalid = c_valid_reg;
    assign m_tdata  = c_data_reg;
    assign m_tlast  = c_last_reg;

    // configuration and frame position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FW_W'(512);
            frame_height_reg <= FH_W'(512);
            col_reg          <= '0;
            row_reg          <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_FRAME_WIDTH)
                frame_width_reg <= pwdata[FW_W-1:0];
            else
                frame_height_reg <= pwdata[FH_W-1:0];
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_acc) begin
            if (col_reg >= col_last) begin
                col_reg <= '0;
                row_reg <= (row_reg >= row_last) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    // line stores
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            up_rd_reg  <= line_upper[col_reg];
            mid_rd_reg <= line_middle[col_reg];
        end
        if (a_adv) begin
            line_upper[a_col_reg]  <= mid_rd_reg;
            line_middle[a_col_reg] <= a_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            for (int i = 0; i < WIN_N; i++) begin
                win_reg[i] <= '0;
            end
        end else begin
            if (s_acc) begin
                a_valid_reg <= 1'b1;
            end else if (a_adv) begin
                a_valid_reg <= 1'b0;
            end

            if (a_adv) begin
                b_valid_reg <= 1'b1;
                for (int r = 0; r < 3; r++) begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= up_rd_reg;
                win_reg[5] <= mid_rd_reg;
                win_reg[8] <= a_pix_reg;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end

            if (b_adv && b_emit_reg) begin
                c_valid_reg <= 1'b1;
            end else if (m_tready) begin
                c_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            a_pix_reg  <= s_tdata;
            a_col_reg  <= col_reg;
            a_emit_reg <= (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
            a_last_reg <= (col_reg >= col_last) && (row_reg >= row_last);
        end
        if (a_adv) begin
            b_emit_reg <= a_emit_reg;
            b_last_reg <= a_last_reg;
        end
        if (b_adv && b_emit_reg) begin
            c_data_reg <= median9(win_reg);
            c_last_reg <= b_last_reg;
        end
    end

endmodule

// ===== dv/median_filter_3x3_test.sv =====
// Self-checking testbench for median_filter_3x3: streams frames through the pixel port,
// programs the frame size over APB and checks every median against a local prediction.
// Depends on mf3_pkg and median_filter_3x3.
module median_filter_3x3_test;
    import mf3_pkg::*;

    localparam int MAX_W       = 1024;
    localparam int STALL_LIMIT = 10000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_GAP   = 8;
    localparam int RAND_ITEMS  = 1600;

    typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_CLUSTER} pix_style_t;

    typedef struct {
        pixel_t median;
        logic   last;
    } median_rec_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    pixel_t               s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    pixel_t               m_tdata;
    logic                 m_tlast;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // pending pixels and predicted medians
    pixel_t       pixel_q [$];
    median_rec_t  median_q [$];

    // local copy of the filter state
    logic [FW_W-1:0] frame_w;
    logic [FH_W-1:0] frame_h;
    pixel_t          upper_row [MAX_W];
    pixel_t          middle_row [MAX_W];
    win_t            window;
    int              col_cnt;
    int              row_cnt;

    int              errors;
    int              send_idle;
    int              recv_idle;
    int              rand_count;
    int              idle_cycles;
    int              hold_cnt;
    logic            hold_req;
    logic            hold_ack;
    median_rec_t     oldest;

    median_filter_3x3 uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic int active_width();
        int w;
        w = int'(frame_w);
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = int'(frame_h);
        if (h < 3) h = 3;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void predict_pixel(input pixel_t pix);
        int          w;
        int          h;
        int          idx;
        int          j;
        bit          at_last_col;
        bit          at_last_row;
        pixel_t      up;
        pixel_t      mid;
        pixel_t      t;
        win_t        srt;
        median_rec_t rec;
        w = active_width();
        h = active_height();
        idx = (col_cnt < MAX_W) ? col_cnt : MAX_W - 1;
        up = upper_row[idx];
        mid = middle_row[idx];
        at_last_col = (col_cnt >= w - 1);
        at_last_row = (row_cnt >= h - 1);
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2] = up;
        window[5] = mid;
        window[8] = pix;
        upper_row[idx] = mid;
        middle_row[idx] = pix;
        if (row_cnt >= 2 && col_cnt >= 2) begin
            srt = window;
            for (int i = 1; i < WIN_N; i++) begin
                t = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > t) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = t;
            end
            rec.median = srt[4];
            rec.last = at_last_col && at_last_row;
            median_q.push_back(rec);
        end
        if (at_last_col) begin
            col_cnt = 0;
            row_cnt = at_last_row ? 0 : row_cnt + 1;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endfunction

    function automatic pixel_t gen_pixel(input pix_style_t style, input int base);
        case (style)
            PIX_EXTREME: begin
                return ($urandom_range(1) == 1) ? 8'hFF : 8'h00;
            end
            PIX_CLUSTER: begin
                return pixel_t'(base + $urandom_range(3));
            end
            default: begin
                return pixel_t'($urandom_range(255));
            end
        endcase
    endfunction

    task automatic push_pixels(input int n, input pix_style_t style);
        int base;
        base = $urandom_range(252);
        repeat (n) pixel_q.push_back(gen_pixel(style, base));
    endtask

    // sampled away from the active edge so driver and monitor updates have settled
    task automatic wait_idle();
        while (pixel_q.size() != 0 || s_tvalid || median_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_GAP) @(posedge aclk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_FRAME_WIDTH) begin
            frame_w = data[FW_W-1:0];
        end else begin
            frame_h = data[FH_W-1:0];
        end
        col_cnt = 0;
        row_cnt = 0;
    endtask

    // upper data bits are random; only the register width is kept
    task automatic set_frame(input int w_val, input int h_val);
        logic [31:0] d;
        wait_idle();
        d = $urandom;
        d[FW_W-1:0] = w_val[FW_W-1:0];
        apb_write(REG_FRAME_WIDTH, d);
        d = $urandom;
        d[FH_W-1:0] = h_val[FH_W-1:0];
        apb_write(REG_FRAME_HEIGHT, d);
    endtask

    // pixel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_pixel(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pixel_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result sink with random and long back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
            hold_ack <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_cnt <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (median_q.size() == 0) begin
                if (errors < 10)
                    $display("unexpected transaction: median %0d last %0b", m_tdata, m_tlast);
                errors = errors + 1;
            end else begin
                oldest = median_q.pop_front();
                if (m_tdata !== oldest.median || m_tlast !== oldest.last) begin
                    if (errors < 10)
                        $display("mismatch: expected median %0d last %0b, got median %0d last %0b",
                                 oldest.median, oldest.last, m_tdata, m_tlast);
                    errors = errors + 1;
                end
            end
        end
    end

    // no-progress watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int         w_eff;
        int         h_eff;
        int         w_reg;
        int         h_reg;
        int         n;
        pix_style_t style;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        aresetn  = 1'b0;
        hold_req = 1'b0;
        errors   = 0;
        send_idle = 15;
        recv_idle = 76;
        rand_count = 0;
        frame_w  = 11'd512;
        frame_h  = 13'd512;
        col_cnt  = 0;
        row_cnt  = 0;
        for (int i = 0; i < WIN_N; i++) window[i] = '0;
        for (int i = 0; i < MAX_W; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // a few pixels at the reset frame size, then a restart by register write
        push_pixels(5, PIX_RANDOM);
        // widths and heights below three act as three; two frames back to back
        set_frame(0, 1);
        repeat (9) pixel_q.push_back(8'hFF);
        for (int i = 0; i < 9; i++) pixel_q.push_back((i % 2) ? 8'hFF : 8'h00);

        // width above the maximum, with a long output stall right at its start
        set_frame(2047, 3);
        @(posedge aclk);
        hold_req <= ~hold_req;
        push_pixels(32, PIX_RANDOM);

        while (rand_count < RAND_ITEMS) begin
            if (rand_count >= (2 * RAND_ITEMS) / 3) begin
                send_idle = 0;
                recv_idle = 0;
            end else if (rand_count >= RAND_ITEMS / 3) begin
                send_idle = 76;
                recv_idle = 15;
            end
            w_eff = ($urandom_range(7) == 0) ? $urandom_range(13, 64) : $urandom_range(3, 12);
            h_eff = $urandom_range(3, 8);
            w_reg = w_eff;
            h_reg = h_eff;
            if (w_eff == 3 && $urandom_range(1) == 0) w_reg = $urandom_range(0, 2);
            if (h_eff == 3 && $urandom_range(1) == 0) h_reg = $urandom_range(0, 2);
            set_frame(w_reg, h_reg);
            n = $urandom_range(1, 2) * w_eff * h_eff;
            if ($urandom_range(3) == 0) n = n + $urandom_range(1, w_eff * h_eff - 1);
            case ($urandom_range(5))
                0: style = PIX_EXTREME;
                1, 2: style = PIX_CLUSTER;
                default: style = PIX_RANDOM;
            endcase
            push_pixels(n, style);
            rand_count = rand_count + n;
        end

        // height above the maximum; the output stalls while the sender keeps offering
        set_frame(0, 8191);
        @(posedge aclk);
        hold_req <= ~hold_req;
        push_pixels(3 * 40, PIX_RANDOM);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (errors == 0 && median_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== median_filter_3x3.f =====
design/mf3_pkg.sv
design/median_filter_3x3.sv
dv/median_filter_3x3_test.sv
